FILE: hw/rtl/logit_sigmoid_threshold_select_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sigmoid threshold classifier
// Concurrent checks on the rising edge of clock; empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef LOGIT_SIGMOID_THRESHOLD_SELECT_TOP_DEFINES_SVH
`define LOGIT_SIGMOID_THRESHOLD_SELECT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that is switched off while reset is high
`define LSTS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check that also runs through reset
`define LSTS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LSTS_ASSERT(label, prop, msg)
`define LSTS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: hw/rtl/lsts_pkg.sv
// ----------------------------------------------------------------------------
// lsts_pkg
// Shared constants, types and codes of the sigmoid threshold classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package lsts_pkg;

   // Field widths
   localparam int unsigned LOGIT_W    = 16;
   localparam int unsigned LABELS_W   = 11;
   localparam int unsigned CLASS_W    = 10;
   localparam int unsigned PROB_W     = 16;
   localparam int unsigned ROW_W      = 16;
   localparam int unsigned ROW_LEN_W  = 11;
   localparam int unsigned THRESH_W   = 16;

   localparam int unsigned MAX_CLASSES         = 1024;
   localparam int unsigned SIGMOID_TABLE_DEPTH = 2048;
   localparam int unsigned SIG_ADDR_W          = $clog2(SIGMOID_TABLE_DEPTH);
   // |logit| >> 4 before saturation
   localparam int unsigned MAG_IDX_W           = LOGIT_W + 1 - 4;

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE      = 2'd0,
      CSR_THRESHOLD = 2'd1,
      CSR_ROW_LEN   = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_MULTI  = 1'b0,
      MODE_SINGLE = 1'b1
   } mode_type;

   localparam logic [THRESH_W-1:0]  THRESH_RESET  = 16'd32768;
   localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 11'd2;

   // Sigmoid table generation: q holds e^(-k/256) in Q62, stepped by STEP
   localparam int unsigned Q_W = 63;
   localparam logic [63:0] T0  = 64'h4000_0000_0000_0000;
   localparam logic [63:0] T1  = T0  / 64'd256;
   localparam logic [63:0] T2  = T1  / 64'd512;
   localparam logic [63:0] T3  = T2  / 64'd768;
   localparam logic [63:0] T4  = T3  / 64'd1024;
   localparam logic [63:0] T5  = T4  / 64'd1280;
   localparam logic [63:0] T6  = T5  / 64'd1536;
   localparam logic [63:0] T7  = T6  / 64'd1792;
   localparam logic [63:0] T8  = T7  / 64'd2048;
   localparam logic [63:0] T9  = T8  / 64'd2304;
   localparam logic [63:0] T10 = T9  / 64'd2560;
   localparam logic [63:0] T11 = T10 / 64'd2816;
   localparam logic [63:0] T12 = T11 / 64'd3072;
   localparam logic [63:0] STEP = T0 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9
                                  + T10 - T11 + T12;
   localparam logic [31:0] STEP_LO = STEP[31:0];
   localparam logic [31:0] STEP_HI = STEP[63:32];
   localparam logic [Q_W-1:0] Q_ONE = T0[Q_W-1:0];

   // Rounded divide 65535*2^40 / (2^40 + q>>22)
   localparam int unsigned DEN_W      = 42;
   localparam int unsigned DIVISOR_W  = DEN_W + 1;
   localparam int unsigned DIVIDEND_W = 58;
   localparam int unsigned DIV_STEPS  = 17;
   localparam int unsigned FILL_CNT_W = $clog2(DIV_STEPS);
   localparam int unsigned MUL_CYCLES = 5;
   localparam int unsigned ACC_W      = 126;
   localparam logic [DIVIDEND_W-1:0] DIV_NUM2  = 58'd65535 << 41;
   localparam logic [DEN_W-1:0]      DEN_ONE   = 42'd1 << 40;

   typedef enum logic [2:0] {
      FILL_SETUP,
      FILL_DIV,
      FILL_MUL,
      FILL_WRITE,
      FILL_DONE
   } fill_state_type;

   typedef struct packed {
      logic                  valid;
      logic [SIG_ADDR_W-1:0] addr;
      logic [PROB_W-1:0]     data;
   } rom_write_type;

   typedef struct packed {
      logic [CLASS_W-1:0] class_index;
      logic [PROB_W-1:0]  probability;
      logic               known_label;
      logic [ROW_W-1:0]   row_index;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } rsp_push_type;

   // Result queue: output register plus room for the items in flight
   localparam int unsigned RSP_QUEUE_DEPTH = 3;
   localparam int unsigned QPTR_W          = $clog2(RSP_QUEUE_DEPTH);
   localparam int unsigned QCNT_W          = $clog2(RSP_QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              full;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/lsts_stream_if.sv
// ----------------------------------------------------------------------------
// lsts stream interfaces
// Valid/ready channels for logits in and reported classes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsts_req_if import lsts_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [LOGIT_W-1:0]  logit;
   logic        [LABELS_W-1:0] labels_in_row;

   modport source (output valid, logit, labels_in_row, input ready);
   modport sink   (input valid, logit, labels_in_row, output ready);
endinterface

interface lsts_rsp_if import lsts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CLASS_W-1:0] class_index;
   logic [PROB_W-1:0]  probability;
   logic               known_label;
   logic [ROW_W-1:0]   row_index;

   modport source (output valid, class_index, probability, known_label, row_index,
                   input ready);
   modport sink   (input valid, class_index, probability, known_label, row_index,
                   output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/logit_sigmoid_threshold_select_top.sv
// Path: the table RAM read register, then a result queue slot, which drives rsp.
// Throughput: one logit per cycle once the table is built, set by the single
//   read port of the sigmoid table RAM; rsp back-pressure stalls req only when
//   the queued results and the item in flight fill the three-entry queue.
// Reset (synchronous, active high) clears the row state and starts the table
//   build, with req.ready held low until the build is done.
// ----------------------------------------------------------------------------
// logit_sigmoid_threshold_select_top
// Maps a stream of logits through a sigmoid table and reports classes whose
// probability reaches a threshold, either every one or the argmax per row.
// ----------------------------------------------------------------------------
`default_nettype none
`include "logit_sigmoid_threshold_select_top_defines.svh"

module logit_sigmoid_threshold_select_top import lsts_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   lsts_req_if.sink                    req_if,
   lsts_rsp_if.source                  rsp_if,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [MAG_IDX_W-1:0] ROM_LAST = MAG_IDX_W'(SIGMOID_TABLE_DEPTH - 1);
   localparam logic [ROW_LEN_W-1:0] LEN_MAX  = ROW_LEN_W'(MAX_CLASSES);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   mode_type             mode_ff, mode_in;
   logic [THRESH_W-1:0]  thresh_ff, thresh_in;
   logic [ROW_LEN_W-1:0] row_len_cfg_ff, row_len_cfg_in;

   always_comb begin
      mode_in        = mode_ff;
      thresh_in      = thresh_ff;
      row_len_cfg_in = row_len_cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:      mode_in        = mode_type'(csr_wdata[0]);
            CSR_THRESHOLD: thresh_in      = csr_wdata[THRESH_W-1:0];
            CSR_ROW_LEN:   row_len_cfg_in = csr_wdata[ROW_LEN_W-1:0];
            default:       mode_in        = mode_ff;   // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_MULTI;
         thresh_ff      <= THRESH_RESET;
         row_len_cfg_ff <= ROW_LEN_RESET;
      end else begin
         mode_ff        <= mode_in;
         thresh_ff      <= thresh_in;
         row_len_cfg_ff <= row_len_cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sigmoid table: built by the fill sequencer, then read once per logit
   // ---------------------------------------------------------------------
   rom_write_type         fill_wr;
   logic                  fill_done;
   logic                  rom_rd_en;
   logic [SIG_ADDR_W-1:0] rom_rd_addr;
   logic [PROB_W-1:0]     rom_rd_data;

   lsts_fill u_fill (
      .clock  (clock),
      .reset  (reset),
      .rom_wr (fill_wr),
      .done   (fill_done)
   );

   lsts_ram #(
      .WIDTH (PROB_W),
      .DEPTH (SIGMOID_TABLE_DEPTH)
   ) u_sig_ram (
      .clock   (clock),
      .wr_en   (fill_wr.valid),
      .wr_addr (fill_wr.addr),
      .wr_data (fill_wr.data),
      .rd_en   (rom_rd_en),
      .rd_addr (rom_rd_addr),
      .rd_data (rom_rd_data)
   );

   // ---------------------------------------------------------------------
   // Stage 0: take the transfer, fold the sign away and address the table
   // ---------------------------------------------------------------------
   queue_status_type  q_status;
   rsp_push_type      rsp_push;
   logic              req_xfer;
   logic              in_neg;
   logic [LOGIT_W:0]  in_mag;
   logic [MAG_IDX_W-1:0] in_idx;

   logic                s1_valid_ff;
   logic                s1_neg_ff;
   logic [LABELS_W-1:0] s1_labels_ff;

   // Reserve a queue slot for every item already read from the table, so the
   // queue can never overflow
   assign req_if.ready = fill_done &&
      (({1'b0, q_status.count} + (QCNT_W + 1)'(s1_valid_ff))
       < (QCNT_W + 1)'(RSP_QUEUE_DEPTH));
   assign req_xfer = req_if.valid && req_if.ready;

   always_comb begin
      in_neg = req_if.logit[LOGIT_W-1];
      in_mag = in_neg ? ((LOGIT_W + 1)'(1) << LOGIT_W) - {1'b0, req_if.logit}
                      : {1'b0, req_if.logit};
      in_idx = in_mag[LOGIT_W:4];
      // Saturate the address at the last table entry for the largest magnitude
      rom_rd_addr = (in_idx > ROM_LAST) ? SIG_ADDR_W'(ROM_LAST)
                                        : SIG_ADDR_W'(in_idx);
      rom_rd_en = req_xfer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_neg_ff    <= in_neg;
         s1_labels_ff <= req_if.labels_in_row;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: probability, row tracking and the running maximum
   // ---------------------------------------------------------------------
   logic [CLASS_W-1:0] class_counter_ff, class_counter_in;
   logic [PROB_W-1:0]  best_prob_ff, best_prob_in;
   logic [CLASS_W-1:0] best_index_ff, best_index_in;
   logic [ROW_W-1:0]   row_counter_ff, row_counter_in;

   logic [PROB_W-1:0]    prob;
   logic [ROW_LEN_W-1:0] row_len;
   logic                 row_end;
   logic                 better;
   logic [PROB_W-1:0]    run_prob;
   logic [CLASS_W-1:0]   run_index;

   always_comb begin
      prob = s1_neg_ff ? ({PROB_W{1'b1}} - rom_rd_data) : rom_rd_data;

      // A zero length acts as one, an oversized one as the largest row
      if (row_len_cfg_ff == '0) begin
         row_len = ROW_LEN_W'(1);
      end else if (row_len_cfg_ff > LEN_MAX) begin
         row_len = LEN_MAX;
      end else begin
         row_len = row_len_cfg_ff;
      end
      row_end = ((ROW_LEN_W'(class_counter_ff) + ROW_LEN_W'(1)) >= row_len);

      // Strict maximum: the earliest class wins a tie
      better    = (prob > best_prob_ff);
      run_prob  = better ? prob : best_prob_ff;
      run_index = better ? class_counter_ff : best_index_ff;

      rsp_push.valid = 1'b0;
      rsp_push.rsp.row_index = row_counter_ff;
      unique case (mode_ff)
         MODE_MULTI: begin
            rsp_push.valid               = s1_valid_ff && (prob >= thresh_ff);
            rsp_push.rsp.class_index     = class_counter_ff;
            rsp_push.rsp.probability     = prob;
            rsp_push.rsp.known_label     =
               (LABELS_W'(class_counter_ff) < s1_labels_ff);
         end
         MODE_SINGLE: begin
            rsp_push.valid               = s1_valid_ff && row_end &&
                                           (run_prob >= thresh_ff);
            rsp_push.rsp.class_index     = run_index;
            rsp_push.rsp.probability     = run_prob;
            rsp_push.rsp.known_label     = (LABELS_W'(run_index) < s1_labels_ff);
         end
         default: begin
            rsp_push.rsp.class_index     = class_counter_ff;
            rsp_push.rsp.probability     = prob;
            rsp_push.rsp.known_label     = 1'b0;
         end
      endcase

      class_counter_in = class_counter_ff;
      best_prob_in     = best_prob_ff;
      best_index_in    = best_index_ff;
      row_counter_in   = row_counter_ff;
      if (s1_valid_ff) begin
         if (row_end) begin
            // Restart the row and advance the row number (wraps)
            class_counter_in = '0;
            best_prob_in     = '0;
            best_index_in    = '0;
            row_counter_in   = row_counter_ff + ROW_W'(1);
         end else begin
            class_counter_in = class_counter_ff + CLASS_W'(1);
            // The running maximum only moves in argmax mode
            if (mode_ff == MODE_SINGLE) begin
               best_prob_in  = run_prob;
               best_index_in = run_index;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_counter_ff <= '0;
         best_prob_ff     <= '0;
         best_index_ff    <= '0;
         row_counter_ff   <= '0;
      end else begin
         class_counter_ff <= class_counter_in;
         best_prob_ff     <= best_prob_in;
         best_index_ff    <= best_index_in;
         row_counter_ff   <= row_counter_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result queue: parts the rsp side from the pipeline
   // ---------------------------------------------------------------------
   lsts_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .status (q_status),
      .rsp_if (rsp_if)
   );

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `LSTS_ASSERT(a_no_xfer_during_fill, req_xfer |-> fill_done, "logit taken before table built")
   `LSTS_ASSERT(a_queue_no_overflow, rsp_push.valid |-> !q_status.full, "result queue overflow")
   `LSTS_ASSERT(a_row_restart, (s1_valid_ff && row_end) |=> (class_counter_ff == '0), "row did not restart")
   `LSTS_ASSERT_ALWAYS(a_idle_after_reset, $past(reset) |-> !rsp_if.valid, "result after reset")

endmodule

`default_nettype wire

FILE: hw/rtl/lsts_ram.sv
// ----------------------------------------------------------------------------
// lsts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsts_ram #(
   parameter  int unsigned WIDTH  = 16,
   parameter  int unsigned DEPTH  = 2048,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/lsts_fill.sv
// ----------------------------------------------------------------------------
// lsts_fill
// Builds the sigmoid table after reset, one entry after another.
// ----------------------------------------------------------------------------
`default_nettype none

module lsts_fill import lsts_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   output rom_write_type rom_wr,
   output logic         done
);

   fill_state_type state_ff, state_in;

   logic [FILL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SIG_ADDR_W-1:0] entry_ff, entry_in;
   logic [Q_W-1:0]        q_ff, q_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIV_STEPS-1:0]  low_ff, low_in;
   logic [63:0]           pp_ff, pp_in;
   logic [1:0]            pp_shift_ff, pp_shift_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;

   logic do_setup, do_div, do_issue, do_acc, do_write;
   logic div_last, mul_last, entry_last;

   logic [DEN_W-1:0]      den;
   logic [DIVIDEND_W-1:0] dividend;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_sub;
   logic                  fits;
   logic [31:0]           mul_a, mul_b;
   logic [ACC_W-1:0]      addend;

   assign div_last   = (cnt_ff == FILL_CNT_W'(DIV_STEPS - 1));
   assign mul_last   = (cnt_ff == FILL_CNT_W'(MUL_CYCLES - 1));
   assign entry_last = (entry_ff == SIG_ADDR_W'(SIGMOID_TABLE_DEPTH - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FILL_SETUP: state_in = FILL_DIV;
         FILL_DIV:   if (div_last) state_in = FILL_MUL;
         FILL_MUL:   if (mul_last) state_in = FILL_WRITE;
         FILL_WRITE: state_in = entry_last ? FILL_DONE : FILL_SETUP;
         FILL_DONE:  state_in = FILL_DONE;
         default:    state_in = FILL_SETUP;
      endcase
   end

   // Controls
   always_comb begin
      do_setup = 1'b0;
      do_div   = 1'b0;
      do_issue = 1'b0;
      do_acc   = 1'b0;
      do_write = 1'b0;
      done     = 1'b0;
      unique case (state_ff)
         FILL_SETUP: do_setup = 1'b1;
         FILL_DIV:   do_div = 1'b1;
         FILL_MUL: begin
            do_issue = (cnt_ff < FILL_CNT_W'(MUL_CYCLES - 1));
            do_acc   = (cnt_ff != '0);
         end
         FILL_WRITE: do_write = 1'b1;
         FILL_DONE:  done = 1'b1;
         default:    done = 1'b0;
      endcase
   end

   // Divider and multiplier datapath
   always_comb begin
      den       = DEN_ONE + DEN_W'(q_ff[Q_W-1:22]);
      dividend  = DIV_NUM2 + DIVIDEND_W'(den);
      trial     = {rem_ff, low_ff[DIV_STEPS-1]};
      trial_sub = trial - {1'b0, divisor_ff};
      fits      = (trial >= {1'b0, divisor_ff});

      mul_a = cnt_ff[1] ? {1'b0, q_ff[Q_W-1:32]} : q_ff[31:0];
      mul_b = cnt_ff[0] ? STEP_HI : STEP_LO;

      unique case (pp_shift_ff)
         2'd0:    addend = ACC_W'(pp_ff);
         2'd1:    addend = ACC_W'(pp_ff) << 32;
         default: addend = ACC_W'(pp_ff) << 64;
      endcase

      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      low_in      = low_ff;
      pp_in       = pp_ff;
      pp_shift_in = pp_shift_ff;
      acc_in      = acc_ff;
      q_in        = q_ff;
      entry_in    = entry_ff;
      cnt_in      = '0;

      if (do_setup) begin
         rem_in     = DIVISOR_W'(dividend[DIVIDEND_W-1:DIV_STEPS]);
         low_in     = dividend[DIV_STEPS-1:0];
         divisor_in = {den, 1'b0};
         acc_in     = '0;
      end
      if (do_div) begin
         rem_in = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         low_in = {low_ff[DIV_STEPS-2:0], fits};
         cnt_in = div_last ? '0 : cnt_ff + FILL_CNT_W'(1);
      end
      if (state_ff == FILL_MUL) begin
         cnt_in = mul_last ? '0 : cnt_ff + FILL_CNT_W'(1);
      end
      if (do_issue) begin
         pp_in       = mul_a * mul_b;
         pp_shift_in = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
      end
      if (do_acc) begin
         acc_in = acc_ff + addend;
      end
      if (do_write) begin
         q_in     = acc_ff[Q_W+61:62];
         entry_in = entry_ff + SIG_ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FILL_SETUP;
         cnt_ff   <= '0;
         entry_ff <= '0;
         q_ff     <= Q_ONE;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         entry_ff <= entry_in;
         q_ff     <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      low_ff      <= low_in;
      pp_ff       <= pp_in;
      pp_shift_ff <= pp_shift_in;
      acc_ff      <= acc_in;
   end

   assign rom_wr.valid = do_write;
   assign rom_wr.addr  = entry_ff;
   assign rom_wr.data  = low_ff[PROB_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/lsts_rsp_queue.sv
// ----------------------------------------------------------------------------
// lsts_rsp_queue
// Small result queue that drives the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lsts_rsp_queue import lsts_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  rsp_push_type      push,
   output queue_status_type  status,
   lsts_rsp_if.source        rsp_if
);

   rsp_type           slot_ff [RSP_QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;
   rsp_type           head;

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(RSP_QUEUE_DEPTH - 1);

   assign pop = rsp_if.valid && rsp_if.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      count_in = count_ff + QCNT_W'(push.valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.rsp;
      end
   end

   assign head               = slot_ff[rd_ptr_ff];
   assign rsp_if.valid       = (count_ff != '0);
   assign rsp_if.class_index = head.class_index;
   assign rsp_if.probability = head.probability;
   assign rsp_if.known_label = head.known_label;
   assign rsp_if.row_index   = head.row_index;

   assign status.count = count_ff;
   assign status.full  = (count_ff == QCNT_W'(RSP_QUEUE_DEPTH));

endmodule

`default_nettype wire
